// ----- hw/rtl/rws_pkg.sv -----
package rws_pkg;

    localparam int TABLE_DEPTH  = 256;
    localparam int FITNESS_BITS = 16;
    localparam int IDX_W        = $clog2(TABLE_DEPTH);
    localparam int CNT_W        = IDX_W + 1;
    localparam int TOTAL_W      = FITNESS_BITS + IDX_W;
    localparam int FRAC_W       = 16;
    localparam int PROD_W       = TOTAL_W + FRAC_W;
    localparam int POP_W        = 9;
    localparam int POP_RESET    = 256;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SELECT = 1'b1;

    localparam logic REG_POP_SIZE = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WR,
        ST_MUL,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

// ----- hw/rtl/roulette_wheel_selector.sv -----
// Sequence: a write beat reads the old entry when accepted, then in ST_WR writes the table
//   and adjusts the total; a select beat scales the total in ST_MUL, scans from entry zero
//   in ST_SCAN (skipped on a zero total) up to a hit or the last active entry, then ST_DONE.
// Flow: s_axis_tready is high only in ST_IDLE, so no beat is taken while one is in progress;
//   the scan reads one table entry a cycle over the single read port; a stalled result holds.
// Reset (aresetn low, synchronous): total zero, population_size 256, table reads zero.
module roulette_wheel_selector
    import rws_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // s_axis_tdata: entry_index[7:0], fitness_value[23:8], random_fraction[39:24],
    //               random_index[47:40]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // chosen_index[7:0]
    output logic        m_axis_tuser,   // used_fallback
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ------------------------------------------------------------------
    // Input beat fields
    // ------------------------------------------------------------------
    logic [7:0]  in_entry_index;
    logic [15:0] in_fitness_value;
    logic [15:0] in_random_fraction;
    logic [7:0]  in_random_index;
    logic        in_hs;

    assign in_entry_index     = s_axis_tdata[7:0];
    assign in_fitness_value   = s_axis_tdata[23:8];
    assign in_random_fraction = s_axis_tdata[39:24];
    assign in_random_index    = s_axis_tdata[47:40];
    assign in_hs              = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    logic [POP_W-1:0] pop_size_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_POP_SIZE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pop_size_reg <= POP_W'(POP_RESET);
        end else if (cfg_wr) begin
            pop_size_reg <= pwdata[POP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_POP_SIZE) ? {{(32-POP_W){1'b0}}, pop_size_reg} : 32'd0;

    // Active count: zero counts as one, clamp to table depth
    logic [CNT_W-1:0] active_n;
    logic [CNT_W-1:0] active_last;

    always_comb begin
        if (pop_size_reg == '0) begin
            active_n = CNT_W'(1);
        end else if (32'(pop_size_reg) > TABLE_DEPTH) begin
            active_n = CNT_W'(TABLE_DEPTH);
        end else begin
            active_n = CNT_W'(pop_size_reg);
        end
    end

    assign active_last = active_n - CNT_W'(1);

    // ------------------------------------------------------------------
    // Fitness table: one read port with registered data, one write port.
    // Valid bits make never-written entries read as zero after reset.
    // ------------------------------------------------------------------
    logic [FITNESS_BITS-1:0] fit_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]  valid_reg;
    logic [IDX_W-1:0]        rd_addr;
    logic [FITNESS_BITS-1:0] rd_data_reg;
    logic                    rd_valid_reg;
    logic [FITNESS_BITS-1:0] rd_fit;
    logic                    mem_we;

    // ------------------------------------------------------------------
    // Control and datapath registers
    // ------------------------------------------------------------------
    state_t                  state_reg, state_next;
    logic [TOTAL_W-1:0]      total_reg, total_next;
    logic [IDX_W-1:0]        wr_idx_reg, wr_idx_next;
    logic [FITNESS_BITS-1:0] wr_val_reg, wr_val_next;
    logic                    wr_en_reg, wr_en_next;
    logic [FRAC_W-1:0]       frac_reg, frac_next;
    logic [7:0]              rnd_idx_reg, rnd_idx_next;
    logic [TOTAL_W-1:0]      thr_reg, thr_next;
    logic [IDX_W-1:0]        scan_idx_reg, scan_idx_next;
    logic [7:0]              res_idx_reg, res_idx_next;
    logic                    res_fb_reg, res_fb_next;
    logic                    m_valid_reg, m_valid_next;
    logic [7:0]              m_idx_reg, m_idx_next;
    logic                    m_fb_reg, m_fb_next;

    logic                    out_free;
    logic                    hit;
    logic                    at_last;
    logic [7:0]              fb_pick;
    logic [PROD_W-1:0]       product;

    always_ff @(posedge aclk) begin
        rd_data_reg <= fit_mem[rd_addr];
        if (mem_we) begin
            fit_mem[wr_idx_reg] <= wr_val_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (mem_we) begin
                valid_reg[wr_idx_reg] <= 1'b1;
            end
        end
    end

    assign rd_fit = rd_valid_reg ? rd_data_reg : '0;

    assign out_free = !m_valid_reg || m_axis_tready;
    assign hit      = thr_reg <= TOTAL_W'(rd_fit);
    assign at_last  = {1'b0, scan_idx_reg} == active_last;
    assign product  = PROD_W'(total_reg) * PROD_W'(frac_reg);

    // Fallback pick: random index clamped to the last active entry
    assign fb_pick = (CNT_W'(rnd_idx_reg) > active_last) ? 8'(active_last) : rnd_idx_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_hs) begin
                    state_next = (s_axis_tuser == FUNC_WRITE) ? ST_WR : ST_MUL;
                end
            end
            ST_WR:   state_next = ST_IDLE;
            ST_MUL:  state_next = (total_reg == '0) ? ST_DONE : ST_SCAN;
            ST_SCAN: begin
                if (hit || at_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath
    always_comb begin
        s_axis_tready = 1'b0;
        mem_we        = 1'b0;
        rd_addr       = IDX_W'(in_entry_index);
        total_next    = total_reg;
        wr_idx_next   = wr_idx_reg;
        wr_val_next   = wr_val_reg;
        wr_en_next    = wr_en_reg;
        frac_next     = frac_reg;
        rnd_idx_next  = rnd_idx_reg;
        thr_next      = thr_reg;
        scan_idx_next = scan_idx_reg;
        res_idx_next  = res_idx_reg;
        res_fb_next   = res_fb_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_idx_next    = m_idx_reg;
        m_fb_next     = m_fb_reg;

        unique case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                // Read the old entry of a write in the accept cycle
                if (in_hs) begin
                    wr_idx_next  = IDX_W'(in_entry_index);
                    wr_val_next  = FITNESS_BITS'(in_fitness_value);
                    wr_en_next   = 32'(in_entry_index) < TABLE_DEPTH;
                    frac_next    = in_random_fraction;
                    rnd_idx_next = in_random_index;
                end
            end
            ST_WR: begin
                // Replace the entry, adjust the total by new minus old
                if (wr_en_reg) begin
                    mem_we     = 1'b1;
                    total_next = total_reg - TOTAL_W'(rd_fit) + TOTAL_W'(wr_val_reg);
                end
            end
            ST_MUL: begin
                // Scale the total, start the scan at entry zero
                rd_addr       = '0;
                thr_next      = product[PROD_W-1:FRAC_W];
                scan_idx_next = '0;
                if (total_reg == '0) begin
                    res_idx_next = fb_pick;
                    res_fb_next  = 1'b1;
                end
            end
            ST_SCAN: begin
                // Prefetch the next entry while testing this one
                rd_addr = scan_idx_reg + IDX_W'(1);
                if (hit) begin
                    res_idx_next = 8'(scan_idx_reg);
                    res_fb_next  = 1'b0;
                end else if (at_last) begin
                    res_idx_next = fb_pick;
                    res_fb_next  = 1'b1;
                end else begin
                    thr_next      = thr_reg - TOTAL_W'(rd_fit);
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            ST_DONE: begin
                // Hold the result until the output register frees up
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_idx_next   = res_idx_reg;
                    m_fb_next    = res_fb_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wr_idx_reg   <= wr_idx_next;
        wr_val_reg   <= wr_val_next;
        wr_en_reg    <= wr_en_next;
        frac_reg     <= frac_next;
        rnd_idx_reg  <= rnd_idx_next;
        thr_reg      <= thr_next;
        scan_idx_reg <= scan_idx_next;
        res_idx_reg  <= res_idx_next;
        res_fb_reg   <= res_fb_next;
        m_idx_reg    <= m_idx_next;
        m_fb_reg     <= m_fb_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_idx_reg;
    assign m_axis_tuser  = m_fb_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_write_goes_to_update: assert property (@(posedge aclk) disable iff (!aresetn)
        in_hs && (s_axis_tuser == FUNC_WRITE) |=> state_reg == ST_WR)
        else $error("write beat did not enter the update cycle");

    a_zero_total_fallback: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) && (total_reg == '0) |=> (state_reg == ST_DONE) && res_fb_reg)
        else $error("zero total did not take the fallback");

    a_scan_in_population: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> {1'b0, scan_idx_reg} < active_n)
        else $error("scan ran past the active population");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result appeared without a finished selection");

endmodule
